[sv/mssd_pkg.sv]
// Shared types, register indexes and glyph tables of the seven-segment display driver.
`default_nettype none

package mssd_pkg;

  // Fixed port widths of the channels.
  localparam int unsigned IN_VALUE_W = 16;
  localparam int unsigned EN_W       = 4;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned POS_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Item command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ERROR_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RIGHT_ALIGNED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DWELL_TICKS     = 2'd2;

  // Register reset values.
  localparam logic [15:0] RST_ERROR_THRESHOLD = 16'd150;
  localparam logic        RST_RIGHT_ALIGNED   = 1'b1;
  localparam logic [7:0]  RST_DWELL_TICKS     = 8'd4;

  // Divide by ten: q = (v * RECIP_TEN) >> RECIP_SHIFT is exact for every 32-bit v.
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] error_threshold;
    logic        right_aligned;
    logic [7:0]  dwell_ticks;
  } cfg_t;

  // Segment pattern of a decimal digit, bit0 = A .. bit6 = G, bit7 = dot.
  function automatic logic [SEG_W-1:0] digit_glyph(input logic [3:0] d);
    logic [SEG_W-1:0] g;
    case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h67;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // Error pattern E, r, 0, r with dot.
  function automatic logic [SEG_W-1:0] error_glyph(input logic [1:0] i);
    logic [SEG_W-1:0] g;
    case (i)
      2'd0:    g = 8'h79;
      2'd1:    g = 8'h50;
      2'd2:    g = 8'h3F;
      2'd3:    g = 8'hD0;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[sv/mssd_front.sv]
// Front end: configuration registers, value and scan state, item classification.
`default_nettype none

module mssd_front #(
  parameter int unsigned DIGITS     = 4,
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned PW         = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mssd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mssd_pkg::CFG_DATA_W-1:0] cfg_data,
  output mssd_pkg::cfg_t                      cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_cmd,
  input  wire logic [mssd_pkg::IN_VALUE_W-1:0] in_value,
  output logic                                push,
  input  wire logic                           push_ready,
  output logic [VALUE_BITS-1:0]               push_value,
  output logic [PW-1:0]                       push_pos,
  output logic                                push_err
);
  import mssd_pkg::*;

  cfg_t                  cfg_r, cfg_nxt;
  logic [VALUE_BITS-1:0] shown_r, shown_nxt;
  logic [PW-1:0]         scan_r, scan_nxt;
  logic [7:0]            dwell_r, dwell_nxt;
  logic [7:0]            dwell_inc;
  logic [7:0]            limit;
  logic                  is_tick;

  assign cfg      = cfg_r;
  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;
  assign is_tick  = (in_cmd == CMD_TICK);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_ERROR_THRESHOLD: cfg_nxt.error_threshold = cfg_data;
        CFG_IDX_RIGHT_ALIGNED:   cfg_nxt.right_aligned   = cfg_data[0];
        CFG_IDX_DWELL_TICKS:     cfg_nxt.dwell_ticks     = cfg_data[7:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  // A load takes effect before the item's pattern is formed.
  always_comb begin
    shown_nxt = shown_r;
    if (push && !is_tick) begin
      shown_nxt = VALUE_BITS'(in_value);
    end
  end

  assign push_value = shown_nxt;
  assign push_pos   = scan_r;
  assign push_err   = 32'(shown_nxt) > 32'(cfg_r.error_threshold);

  // Dwell counting; a zero dwell acts as one, and a counter wrap also moves on.
  assign limit     = (cfg_r.dwell_ticks == 8'd0) ? 8'd1 : cfg_r.dwell_ticks;
  assign dwell_inc = dwell_r + 8'd1;

  always_comb begin
    scan_nxt  = scan_r;
    dwell_nxt = dwell_r;
    if (push && is_tick) begin
      dwell_nxt = dwell_inc;
      if (dwell_inc >= limit || dwell_inc == 8'd0) begin
        dwell_nxt = 8'd0;
        scan_nxt  = (scan_r == PW'(DIGITS - 1)) ? '0 : scan_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.error_threshold <= RST_ERROR_THRESHOLD;
      cfg_r.right_aligned   <= RST_RIGHT_ALIGNED;
      cfg_r.dwell_ticks     <= RST_DWELL_TICKS;
      shown_r               <= '0;
      scan_r                <= '0;
      dwell_r               <= '0;
    end else begin
      cfg_r   <= cfg_nxt;
      shown_r <= shown_nxt;
      scan_r  <= scan_nxt;
      dwell_r <= dwell_nxt;
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_r) < DIGITS)
    else $error("scan position beyond the last digit");

  a_scan_moves_on_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && is_tick) |=> $stable(scan_r))
    else $error("scan moved without a tick");

endmodule

`default_nettype wire

[sv/mssd_queue.sv]
// Short first-in first-out queue between the front end and the digit pipeline.
`default_nettype none

module mssd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("queue count exceeds its depth");

endmodule

`default_nettype wire

[sv/mssd_back.sv]
// Back end: decimal digit pipeline, glyph selection and the output register.
`default_nettype none

module mssd_back #(
  parameter int unsigned DIGITS     = 4,
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned PW         = 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  mssd_pkg::cfg_t                   cfg,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire logic [VALUE_BITS-1:0]       q_value,
  input  wire logic [PW-1:0]               q_pos,
  input  wire logic                        q_err,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mssd_pkg::EN_W-1:0]        out_digit_enable_n,
  output logic [mssd_pkg::SEG_W-1:0]       out_segments,
  output logic [mssd_pkg::POS_W-1:0]       out_position
);
  import mssd_pkg::*;

  // Decimal digits a VALUE_BITS-wide number can have.
  localparam int unsigned NDEC = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned DW   = NDEC * 4;
  localparam int unsigned IW   = $clog2(NDEC + DIGITS + 1);

  logic                  st_vld_r [0:NDEC];
  logic [VALUE_BITS-1:0] st_v_r   [0:NDEC-1];
  logic [DW-1:0]         st_d_r   [0:NDEC];
  logic [PW-1:0]         st_pos_r [0:NDEC];
  logic                  st_err_r [0:NDEC];

  logic                  out_valid_r;
  logic [EN_W-1:0]       out_en_r, out_en_nxt;
  logic [SEG_W-1:0]      out_seg_r, out_seg_nxt;
  logic [POS_W-1:0]      out_pos_r;
  logic                  adv;

  function automatic logic digits_ok(input logic [DW-1:0] d);
    logic ok;
    ok = 1'b1;
    for (int j = 0; j < NDEC; j++) begin
      if (d[j*4 +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // The whole pipeline moves whenever the output register can take a result.
  assign adv     = !out_valid_r || out_ready;
  assign q_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r[0] <= 1'b0;
    end else if (adv) begin
      st_vld_r[0] <= q_valid;
      st_v_r[0]   <= q_value;
      st_d_r[0]   <= '0;
      st_pos_r[0] <= q_pos;
      st_err_r[0] <= q_err;
    end
  end

  // Each stage peels one decimal digit off with a reciprocal multiply.
  for (genvar s = 0; s < NDEC; s++) begin : g_stage
    logic [31:0]           v_ext;
    logic [63:0]           prod;
    logic [VALUE_BITS-1:0] quo;
    logic [VALUE_BITS-1:0] rem;
    logic [DW-1:0]         d_nxt;

    assign v_ext = 32'(st_v_r[s]);
    assign prod  = v_ext * RECIP_TEN;
    assign quo   = VALUE_BITS'(prod >> RECIP_SHIFT);
    assign rem   = st_v_r[s] - ((quo << 3) + (quo << 1));

    always_comb begin
      d_nxt            = st_d_r[s];
      d_nxt[s*4 +: 4]  = rem[3:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        st_vld_r[s+1] <= st_vld_r[s];
        st_pos_r[s+1] <= st_pos_r[s];
        st_err_r[s+1] <= st_err_r[s];
        st_d_r[s+1]   <= d_nxt;
      end
    end

    if (s + 1 < NDEC) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          st_v_r[s+1] <= quo;
        end
      end
    end
  end

  // Glyph selection for the finished item.
  always_comb begin
    logic [DW-1:0] dig;
    logic [PW-1:0] pos;
    logic [IW-1:0] n;
    logic [IW-1:0] k;
    logic          use_dig;
    logic [3:0]    dsel;

    dig  = st_d_r[NDEC];
    pos  = st_pos_r[NDEC];
    n    = '0;
    dsel = 4'd0;

    for (int j = 0; j < NDEC; j++) begin
      if (dig[j*4 +: 4] != 4'd0) begin
        n = IW'(j + 1);
      end
    end

    if (cfg.right_aligned) begin
      k       = IW'(DIGITS - 1) - IW'(pos);
      use_dig = k < IW'(NDEC);
    end else begin
      k       = n - IW'(1) - IW'(pos);
      use_dig = IW'(pos) < n;
    end

    for (int j = 0; j < NDEC; j++) begin
      if (use_dig && k == IW'(j)) begin
        dsel = dig[j*4 +: 4];
      end
    end

    if (st_err_r[NDEC]) begin
      out_seg_nxt = (32'(pos) < 4) ? error_glyph(2'(pos)) : '0;
    end else begin
      out_seg_nxt = digit_glyph(dsel);
    end

    for (int b = 0; b < EN_W; b++) begin
      out_en_nxt[b] = !(32'(pos) == b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_vld_r[NDEC];
      out_en_r    <= out_en_nxt;
      out_seg_r   <= out_seg_nxt;
      out_pos_r   <= POS_W'(st_pos_r[NDEC]);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit_enable_n = out_en_r;
  assign out_segments       = out_seg_r;
  assign out_position       = out_pos_r;

  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    st_vld_r[NDEC] |-> digits_ok(st_d_r[NDEC]))
    else $error("digit pipeline produced a non-decimal digit");

endmodule

`default_nettype wire

[sv/multiplexed_seven_segment_number_display_top.sv]
// Top level of the multiplexed seven-segment number display driver.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    in_cmd, in_value
//   out_      output     out_valid / out_ready  out_digit_enable_n, out_segments, out_position
//   cfg_      input      cfg_we                 cfg_index, cfg_data
//
// One input transfer can be taken every cycle while in_ready is high, and each gives
// one output transfer. Without stalls a result passes the queue, the input register of
// the digit pipeline, one register per digit stage (NDEC = decimal digits of a
// VALUE_BITS-wide value, five at 16 bits) and then the output register.
// Synchronous active-low reset restores the register defaults and clears the scan state.
// A low out_ready freezes the pipeline once a result waits; in_ready drops when the queue
// holds QUEUE_DEPTH items.
`default_nettype none

module multiplexed_seven_segment_number_display_top #(
  parameter int unsigned DIGITS     = 4,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mssd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mssd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_cmd,
  input  wire logic [mssd_pkg::IN_VALUE_W-1:0]  in_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mssd_pkg::EN_W-1:0]             out_digit_enable_n,
  output logic [mssd_pkg::SEG_W-1:0]            out_segments,
  output logic [mssd_pkg::POS_W-1:0]            out_position
);
  import mssd_pkg::*;

  // Width of a scan position, and of one queued item: value, position, error flag.
  localparam int unsigned PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned QW = VALUE_BITS + PW + 1;

  cfg_t                  cfg;
  logic                  push;
  logic                  push_ready;
  logic [VALUE_BITS-1:0] push_value;
  logic [PW-1:0]         push_pos;
  logic                  push_err;
  logic                  q_valid;
  logic                  q_ready;
  logic [QW-1:0]         q_data;

  // The front end owns the registers and all scan state. Every accepted transfer
  // is classified here: a load replaces the shown value before its pattern is
  // formed, a tick advances the dwell count and the scan after it.
  mssd_front #(
    .DIGITS     (DIGITS),
    .VALUE_BITS (VALUE_BITS),
    .PW         (PW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_value   (in_value),
    .push       (push),
    .push_ready (push_ready),
    .push_value (push_value),
    .push_pos   (push_pos),
    .push_err   (push_err)
  );

  // The queue decouples the front end from the digit pipeline so that each
  // side stalls on its own.
  mssd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_ready (push_ready),
    .wr_data  ({push_value, push_pos, push_err}),
    .rd_valid (q_valid),
    .rd_en    (q_ready),
    .rd_data  (q_data)
  );

  // The back end splits the value into decimal digits, one per stage, and
  // picks the glyph for the lit position into the output register.
  mssd_back #(
    .DIGITS     (DIGITS),
    .VALUE_BITS (VALUE_BITS),
    .PW         (PW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_value            (q_data[QW-1 -: VALUE_BITS]),
    .q_pos              (q_data[PW:1]),
    .q_err              (q_data[0]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_digit_enable_n (out_digit_enable_n),
    .out_segments       (out_segments),
    .out_position       (out_position)
  );

endmodule

`default_nettype wire

[bench/tb_multiplexed_seven_segment_number_display_top.sv]
// Self-checking testbench of the multiplexed seven-segment number display driver.
module tb_multiplexed_seven_segment_number_display_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mssd_pkg::*;

  // The scan covers four positions; the top level keeps its default parameters.
  localparam int NUM_POS = 4;
  // Settling wait, with margin over the queue and the digit stages, before the block counts as idle.
  localparam int LATENCY = 12;
  // Length of the long receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 224;
  localparam int REPORT_LIMIT = 10;
  // A register index that the block has no register for; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // Segment patterns, bit0 = A through bit6 = G, bit7 = dot.
  localparam logic [SEG_W-1:0] DIGIT_SEGS [0:9] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };
  // E, r, 0 and r with the dot lit.
  localparam logic [SEG_W-1:0] ERROR_SEGS [0:NUM_POS-1] = '{8'h79, 8'h50, 8'h3F, 8'hD0};

  typedef struct packed {
    logic                  cmd;
    logic [IN_VALUE_W-1:0] value;
  } disp_cmd_t;

  typedef struct packed {
    logic [EN_W-1:0]  enable_n;
    logic [SEG_W-1:0] segs;
    logic [POS_W-1:0] pos;
  } lit_frame_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_cmd = CMD_LOAD;
  logic [IN_VALUE_W-1:0] in_value = '0;
  logic                  out_ready = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [EN_W-1:0]       out_digit_enable_n;
  logic [SEG_W-1:0]      out_segments;
  logic [POS_W-1:0]      out_position;

  // Our own copy of the display state and its registers.
  logic [IN_VALUE_W-1:0] model_value;
  logic [15:0]           model_threshold;
  logic                  model_right;
  logic [7:0]            model_dwell;
  logic [7:0]            model_count;
  logic [POS_W-1:0]      model_scan;

  // Commands waiting for the driver, and the lit frames still owed by the block.
  disp_cmd_t  pending_cmds[$];
  lit_frame_t expected_frames[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cmds_queued = 0;
  int cmds_accepted = 0;
  int fault_count = 0;
  int frames_checked = 0;
  int loads_sent = 0;
  int ticks_sent = 0;
  int error_frames = 0;
  int left_frames = 0;
  int cfg_writes = 0;

  multiplexed_seven_segment_number_display_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_digit_enable_n (out_digit_enable_n),
    .out_segments       (out_segments),
    .out_position       (out_position)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decimal digit number k of v, where digit zero is the units.
  function automatic int decimal_digit(input logic [IN_VALUE_W-1:0] v, input int k);
    int unsigned t;
    t = v;
    for (int i = 0; i < k; i++) t = t / 10;
    return t % 10;
  endfunction

  // Segments shown at one scan position for the current value and settings.
  function automatic logic [SEG_W-1:0] segs_at(input logic [POS_W-1:0] pos);
    int          ndig;
    int unsigned t;
    if (model_value > model_threshold) return ERROR_SEGS[pos];
    if (model_right) return DIGIT_SEGS[decimal_digit(model_value, NUM_POS - 1 - pos)];
    // Left-aligned: the leading digit goes to position zero and the rest fills with zeros.
    ndig = 0;
    for (t = model_value; t > 0; t = t / 10) ndig++;
    if (pos >= ndig) return DIGIT_SEGS[0];
    return DIGIT_SEGS[decimal_digit(model_value, ndig - 1 - pos)];
  endfunction

  // Applies one command to the display state and returns the frame lit while it is handled.
  function automatic lit_frame_t step_display(input disp_cmd_t c);
    lit_frame_t  f;
    logic [7:0]  limit;
    // A load takes effect before the frame is formed, so its frame already shows the value.
    if (c.cmd == CMD_LOAD) model_value = c.value;
    f.pos = model_scan;
    f.enable_n = ~(4'b0001 << model_scan);
    f.segs = segs_at(model_scan);
    if (model_value > model_threshold) error_frames++;
    else if (!model_right) left_frames++;
    if (c.cmd == CMD_TICK) begin
      // A dwell of zero behaves as one. The compare also moves on when the dwell was lowered
      // below the count already reached.
      limit = (model_dwell == 8'd0) ? 8'd1 : model_dwell;
      model_count = model_count + 8'd1;
      if (model_count >= limit || model_count == 8'd0) begin
        model_count = 8'd0;
        model_scan = (model_scan == NUM_POS - 1) ? '0 : model_scan + 1'b1;
      end
    end
    return f;
  endfunction

  task automatic note_fault(input string what, input lit_frame_t want, input lit_frame_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("%0t ns: %s: expected en_n=%h seg=%h pos=%0d, got en_n=%h seg=%h pos=%0d",
               $time, what, want.enable_n, want.segs, want.pos,
               got.enable_n, got.segs, got.pos);
    end
  endtask

  // Sender: offers the next pending command, idling at random between transfers. Once
  // valid is up it stays up with the same payload until the transfer happens.
  always @(posedge clk) begin : cmd_driver
    disp_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_cmd <= nxt.cmd;
        in_value <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  // The hold-off is counted here so that the sender keeps offering commands meanwhile.
  always @(posedge clk) begin : frame_receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks every output transfer against the oldest expected frame, then
  // predicts the frame of any input transfer at the same edge. All values are sampled
  // at the edge, before the nonblocking updates of that edge land.
  always @(posedge clk) begin : frame_monitor
    lit_frame_t got;
    lit_frame_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.enable_n = out_digit_enable_n;
        got.segs = out_segments;
        got.pos = out_position;
        frames_checked++;
        if (expected_frames.size() == 0) begin
          note_fault("frame with nothing expected", '0, got);
        end else begin
          want = expected_frames.pop_front();
          if (got.enable_n !== want.enable_n || got.segs !== want.segs ||
              got.pos !== want.pos) begin
            note_fault("frame mismatch", want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_frames.push_back(step_display('{cmd: in_cmd, value: in_value}));
        cmds_accepted++;
      end
    end
  end

  task automatic queue_cmd(input logic cmd, input logic [IN_VALUE_W-1:0] value);
    pending_cmds.push_back('{cmd: cmd, value: value});
    cmds_queued++;
    if (cmd == CMD_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_cmd(CMD_TICK, IN_VALUE_W'($urandom));
  endtask

  // Waits until every queued command has been taken and every frame has come back,
  // then lets the pipeline settle before anything else changes.
  task automatic drain;
    while (cmds_accepted != cmds_queued || expected_frames.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // One register write. The enable drops in a later step than it rose, so back-to-back
  // writes never assign it twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      CFG_IDX_ERROR_THRESHOLD: model_threshold = data;
      CFG_IDX_RIGHT_ALIGNED:   model_right = data[0];
      CFG_IDX_DWELL_TICKS:     model_dwell = data[7:0];
      default: ;
    endcase
  endtask

  // Value for a load: mostly numbers that matter for the display, sometimes anything.
  function automatic logic [IN_VALUE_W-1:0] pick_value;
    case ($urandom_range(5))
      0: return model_threshold + IN_VALUE_W'($urandom_range(2)) - 1'b1;
      1: return IN_VALUE_W'($urandom_range(9999));
      2: return IN_VALUE_W'($urandom_range(99));
      3: return $urandom_range(1) ? '1 : '0;
      default: return IN_VALUE_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] thr;
    logic [CFG_DATA_W-1:0] dwell;

    // Register values and state right after reset.
    model_threshold = RST_ERROR_THRESHOLD;
    model_right = RST_RIGHT_ALIGNED;
    model_dwell = RST_DWELL_TICKS;
    model_value = '0;
    model_count = '0;
    model_scan = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset settings: zero, the threshold itself, one above it,
    // and the largest value, with enough ticks to walk the scan across positions.
    send_idle_pct = 20;
    recv_idle_pct = 48;
    queue_cmd(CMD_LOAD, 16'd0);
    queue_ticks(4);
    queue_cmd(CMD_LOAD, 16'd150);
    queue_cmd(CMD_LOAD, 16'd151);
    queue_ticks(4);
    queue_cmd(CMD_LOAD, 16'hFFFF);
    queue_ticks(1);
    drain();

    // Highest threshold, left-aligned digits and a dwell of zero, which acts as one.
    // The unused register index must leave everything as it is.
    write_reg(CFG_IDX_ERROR_THRESHOLD, 16'hFFFF);
    write_reg(CFG_IDX_RIGHT_ALIGNED, 16'hFFFE);
    write_reg(CFG_IDX_DWELL_TICKS, 16'hFF00);
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    // Five digits where only four positions exist, then a single digit, then zero.
    queue_cmd(CMD_LOAD, 16'd12345);
    queue_ticks(3);
    queue_cmd(CMD_LOAD, 16'd7);
    queue_ticks(1);
    queue_cmd(CMD_LOAD, 16'd0);
    queue_ticks(1);
    drain();

    // Longest dwell, then the dwell lowered below the count already reached: the scan
    // has to move on at the very next tick.
    write_reg(CFG_IDX_DWELL_TICKS, 16'd255);
    write_reg(CFG_IDX_RIGHT_ALIGNED, 16'd1);
    queue_ticks(3);
    drain();
    write_reg(CFG_IDX_DWELL_TICKS, 16'd1);
    queue_ticks(2);
    drain();

    // Random phases. Each one writes every register, with the extremes up front, and
    // switches the idling pattern: sender light and receiver heavy, then the reverse,
    // then no idling at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin thr = 16'd0;      dwell = 16'd1;   end
        1: begin thr = 16'hFFFF;   dwell = 16'd255; end
        2: begin thr = 16'd9999;   dwell = 16'd0;   end
        default: begin
          thr = $urandom_range(1) ? CFG_DATA_W'($urandom_range(20000))
                                  : CFG_DATA_W'($urandom);
          dwell = {CFG_DATA_W'($urandom) & 16'hFF00} | CFG_DATA_W'($urandom_range(6));
        end
      endcase
      write_reg(CFG_IDX_ERROR_THRESHOLD, thr);
      write_reg(CFG_IDX_RIGHT_ALIGNED, CFG_DATA_W'($urandom));
      write_reg(CFG_IDX_DWELL_TICKS, dwell);
      if (p < 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 48;
      end else if (p < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // A long receiver hold-off while the sender keeps going fills the block up.
      if (p == 2 || p == 6) hold_requests++;
      // Half the phase, a full pause of the sender until every frame is back, then the rest.
      for (int half = 0; half < 2; half++) begin
        for (int i = 0; i < ITEMS_PER_PHASE / 2; i++) begin
          if ($urandom_range(99) < 75) queue_cmd(CMD_TICK, IN_VALUE_W'($urandom));
          else queue_cmd(CMD_LOAD, pick_value());
        end
        drain();
      end
    end

    $display("Ran %0d loads and %0d ticks through %0d register writes; %0d frames checked.",
             loads_sent, ticks_sent, cfg_writes, frames_checked);
    $display("Of those, %0d frames showed the error pattern and %0d left-aligned digits.",
             error_frames, left_frames);
    if (fault_count == 0 && expected_frames.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
sv/mssd_pkg.sv
sv/mssd_front.sv
sv/mssd_queue.sv
sv/mssd_back.sv
sv/multiplexed_seven_segment_number_display_top.sv
bench/tb_multiplexed_seven_segment_number_display_top.sv
